FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the hand oscillation rate detector.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled at the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/hord_pkg.sv
// Package of the hand oscillation rate detector: field widths, register map and reset values.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package hord_pkg;

   localparam int HM_BITS        = 12;
   localparam int THR_BITS       = 12;
   localparam int TPS_BITS       = 32;
   localparam int FREQ_BITS      = 32;
   localparam int FRAC_BITS      = 8;
   localparam int VEL_BITS       = 48;
   localparam int SAMPLE_BITS    = 32;
   localparam int DVD_BITS       = TPS_BITS + FRAC_BITS;
   localparam int SAT_BITS       = DVD_BITS - FREQ_BITS;
   localparam int CNT_BITS       = $clog2(DVD_BITS);

   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_IDX_BITS   = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_HEAD_MARGIN      = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_DIST_THRESHOLD   = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_TICKS_PER_SECOND = 2'd2;

   localparam logic [HM_BITS-1:0]  HEAD_MARGIN_RESET  = 12'd100;
   localparam logic [THR_BITS-1:0] THRESHOLD_RESET    = 12'd20;
   localparam logic [TPS_BITS-1:0] TPS_RESET          = 32'd1000000;

endpackage

`default_nettype wire

FILE: src/hand_oscillation_rate_detector.sv
// Top level of the hand oscillation rate detector: region test, swing tracker,
// bit-serial frequency divider and velocity accumulator. Depends on hord_pkg.
//
// Usage: one frame enters on the req_ channel as a transaction when req_valid is
// high and req_stall is low; exactly one result leaves on the rsp_ channel per
// frame, in order. Configuration registers must be written by the user over the
// csr_ APB port only while no frame is in flight; the block does not enforce this.
// A frame that reports no swing cycle goes from ST_IDLE straight to ST_FINISH,
// where its result is loaded into the output register once that register is
// free; the block then returns to ST_IDLE and can accept the next frame.
// A frame that reports a swing cycle runs a restoring divider that yields one
// quotient bit per cycle in ST_DIVIDE; the velocity is built alongside by
// shifting and adding the swing for each quotient bit. Such a frame passes
// through ST_DIVIDE, ST_DRAIN and ST_FINISH before the next frame can be accepted.
// A finished result waits in the output register while rsp_stall is high; the
// next frame can still be accepted and worked on meanwhile, and its result is
// held back until the output register is free.
// Synchronous reset clears the tracker, the configuration registers to their
// defaults and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module hand_oscillation_rate_detector #(
   parameter int COORD_BITS = 12,
   parameter int TIME_BITS  = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [COORD_BITS-1:0]                req_left_y,
   input  wire  [COORD_BITS-1:0]                req_right_y,
   input  wire  [COORD_BITS-1:0]                req_head_y,
   input  wire  [TIME_BITS-1:0]                 req_time_ticks,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_in_region,
   output logic                                 rsp_cycle_found,
   output logic [hord_pkg::FREQ_BITS-1:0]       rsp_frequency_q8,
   output logic signed [hord_pkg::VEL_BITS-1:0] rsp_velocity_q8,
   output logic [hord_pkg::SAMPLE_BITS-1:0]     rsp_sample_time,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [hord_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire  [hord_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [hord_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   import hord_pkg::*;

   localparam int SUM_BITS = COORD_BITS + 1;
   localparam int LIM_BITS = ((COORD_BITS > HM_BITS) ? COORD_BITS : HM_BITS) + 2;
   localparam int HT_BITS  = ((COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS) + 1;
   localparam int SW_BITS  = COORD_BITS + 3;
   localparam int AW_BITS  = SW_BITS + FREQ_BITS;
   localparam int VW_BITS  = AW_BITS + 1;
   localparam int VX_BITS  = (VW_BITS > VEL_BITS) ? VW_BITS : VEL_BITS;
   localparam logic signed [VX_BITS-1:0] VEL_MAX =
      VX_BITS'({1'b0, {(VEL_BITS-1){1'b1}}});
   localparam logic signed [VX_BITS-1:0] VEL_MIN = -VEL_MAX - VX_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                    state_ff;

   logic [HM_BITS-1:0]           head_margin_ff;
   logic [THR_BITS-1:0]          threshold_ff;
   logic [TPS_BITS-1:0]          tps_ff;

   logic                         moving_up_ff;
   logic [COORD_BITS-1:0]        prev_center_ff;
   logic [COORD_BITS-1:0]        low_turn_ff;
   logic [COORD_BITS-1:0]        high_turn_ff;
   logic                         skip_ff;
   logic [TIME_BITS-1:0]         cycle_start_ff;

   logic                         res_region_ff;
   logic                         res_found_ff;
   logic [SAMPLE_BITS-1:0]       res_sample_ff;
   logic signed [SW_BITS-1:0]    swing_ff;
   logic [TIME_BITS-1:0]         period_ff;
   logic [DVD_BITS-1:0]          dividend_ff;
   logic [TIME_BITS-1:0]         rem_ff;
   logic [FREQ_BITS-1:0]         freq_ff;
   logic                         sat_ff;
   logic                         qbit_ff;
   logic signed [AW_BITS-1:0]    acc_ff;
   logic [CNT_BITS-1:0]          cnt_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_region_ff;
   logic                         rsp_found_ff;
   logic [FREQ_BITS-1:0]         rsp_freq_ff;
   logic signed [VEL_BITS-1:0]   rsp_vel_ff;
   logic [SAMPLE_BITS-1:0]       rsp_sample_ff;

   logic                         accept;
   logic                         out_free;
   logic                         csr_write;
   logic [REG_IDX_BITS-1:0]      csr_index;
   logic [SUM_BITS-1:0]          sum;
   logic [LIM_BITS-1:0]          limit;
   logic                         region;
   logic [COORD_BITS-1:0]        center;
   logic                         rising;
   logic                         falling;
   logic                         tall;
   logic                         cycle_done;
   logic                         report;
   logic signed [SW_BITS-1:0]    swing;
   logic [TIME_BITS-1:0]         period;
   logic [TIME_BITS:0]           trial;
   logic [TIME_BITS:0]           diff;
   logic                         qbit;
   logic signed [AW_BITS-1:0]    acc_in;
   logic signed [VW_BITS-1:0]    swing_vw;
   logic signed [VW_BITS-1:0]    vel_full;
   logic signed [VX_BITS-1:0]    vel_wide;
   logic signed [VX_BITS-1:0]    vel_clamped;
   logic [FREQ_BITS-1:0]         freq_out;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      case (csr_index)
         REG_HEAD_MARGIN:      csr_prdata = CSR_DATA_BITS'(head_margin_ff);
         REG_DIST_THRESHOLD:   csr_prdata = CSR_DATA_BITS'(threshold_ff);
         REG_TICKS_PER_SECOND: csr_prdata = CSR_DATA_BITS'(tps_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Frame front end: region test, rounded center and swing tracker decisions.
   always_comb begin
      sum        = SUM_BITS'(req_left_y) + SUM_BITS'(req_right_y);
      limit      = (LIM_BITS'(req_head_y) + LIM_BITS'(head_margin_ff)) << 1;
      region     = LIM_BITS'(sum) < limit;
      center     = sum[SUM_BITS-1:1] + COORD_BITS'(sum[0] & sum[1]);
      rising     = center > prev_center_ff;
      falling    = center < prev_center_ff;
      tall       = HT_BITS'(low_turn_ff) > (HT_BITS'(high_turn_ff) + HT_BITS'(threshold_ff));
      cycle_done = region && moving_up_ff && rising && tall;
      report     = cycle_done && !skip_ff;
      swing      = (SW_BITS'(low_turn_ff) << 1) - SW_BITS'(high_turn_ff)
                   + SW_BITS'(prev_center_ff);
      period     = req_time_ticks - cycle_start_ff;
   end

   // One restoring division step and one shift-and-add step of the velocity.
   always_comb begin
      trial  = {rem_ff, dividend_ff[DVD_BITS-1]};
      diff   = trial - {1'b0, period_ff};
      qbit   = trial >= {1'b0, period_ff};
      acc_in = (acc_ff <<< 1) + (qbit_ff ? AW_BITS'(swing_ff) : AW_BITS'(0));
   end

   // A saturated frequency uses swing times all ones, else the accumulated product.
   always_comb begin
      swing_vw    = VW_BITS'(swing_ff);
      vel_full    = sat_ff ? ((swing_vw <<< FREQ_BITS) - swing_vw) : VW_BITS'(acc_ff);
      vel_wide    = VX_BITS'(vel_full);
      if (vel_wide > VEL_MAX) begin
         vel_clamped = VEL_MAX;
      end else if (vel_wide < VEL_MIN) begin
         vel_clamped = VEL_MIN;
      end else begin
         vel_clamped = vel_wide;
      end
      freq_out = sat_ff ? '1 : freq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_margin_ff <= HEAD_MARGIN_RESET;
         threshold_ff   <= THRESHOLD_RESET;
         tps_ff         <= TPS_RESET;
         moving_up_ff   <= 1'b0;
         prev_center_ff <= '0;
         low_turn_ff    <= '0;
         high_turn_ff   <= '0;
         skip_ff        <= 1'b0;
         cycle_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_HEAD_MARGIN:      head_margin_ff <= csr_pwdata[HM_BITS-1:0];
               REG_DIST_THRESHOLD:   threshold_ff   <= csr_pwdata[THR_BITS-1:0];
               REG_TICKS_PER_SECOND: tps_ff         <= csr_pwdata[TPS_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_region_ff <= region;
                  res_found_ff  <= report;
                  res_sample_ff <= SAMPLE_BITS'(req_time_ticks);
                  swing_ff      <= swing;
                  period_ff     <= period;
                  dividend_ff   <= {tps_ff, FRAC_BITS'(0)};
                  rem_ff        <= '0;
                  freq_ff       <= '0;
                  sat_ff        <= 1'b0;
                  qbit_ff       <= 1'b0;
                  acc_ff        <= '0;
                  cnt_ff        <= '0;
                  if (!region) begin
                     skip_ff <= 1'b1;
                  end else begin
                     prev_center_ff <= center;
                     if (moving_up_ff) begin
                        if (rising) begin
                           high_turn_ff <= prev_center_ff;
                           if (tall) begin
                              cycle_start_ff <= req_time_ticks;
                              moving_up_ff   <= 1'b0;
                              skip_ff        <= 1'b0;
                           end
                        end
                     end else if (falling) begin
                        low_turn_ff  <= prev_center_ff;
                        moving_up_ff <= 1'b1;
                     end
                  end
                  state_ff <= report ? ST_DIVIDE : ST_FINISH;
               end
            end
            ST_DIVIDE: begin
               rem_ff      <= qbit ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
               dividend_ff <= dividend_ff << 1;
               freq_ff     <= {freq_ff[FREQ_BITS-2:0], qbit};
               qbit_ff     <= qbit;
               acc_ff      <= acc_in;
               if (cnt_ff < CNT_BITS'(SAT_BITS)) begin
                  sat_ff <= sat_ff | qbit;
               end
               cnt_ff <= cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(DVD_BITS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               acc_ff   <= acc_in;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_region_ff <= res_region_ff;
                  rsp_found_ff  <= res_found_ff;
                  rsp_freq_ff   <= res_found_ff ? freq_out : '0;
                  rsp_vel_ff    <= res_found_ff ? vel_clamped[VEL_BITS-1:0] : '0;
                  rsp_sample_ff <= res_sample_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_in_region    = rsp_region_ff;
   assign rsp_cycle_found  = rsp_found_ff;
   assign rsp_frequency_q8 = rsp_freq_ff;
   assign rsp_velocity_q8  = rsp_vel_ff;
   assign rsp_sample_time  = rsp_sample_ff;

endmodule

`default_nettype wire

FILE: src/hord_checker.sv
// Port-level checker of the hand oscillation rate detector and its bind to the top level.
// Depends on hord_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hord_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire                                  rsp_in_region,
   input wire                                  rsp_cycle_found,
   input wire [hord_pkg::FREQ_BITS-1:0]        rsp_frequency_q8,
   input wire signed [hord_pkg::VEL_BITS-1:0]  rsp_velocity_q8
);

   import hord_pkg::*;

   // A result transaction waits until the receiver takes it.
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // Reset leaves no result pending.
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)
   // A frame outside the region never reports a cycle.
   `ASSERT_IMPLIES(a_found_in_region, clock, reset, rsp_valid && rsp_cycle_found, rsp_in_region)
   // Without a cycle, frequency and velocity read as zero.
   `ASSERT_IMPLIES(a_zero_no_cycle, clock, reset, rsp_valid && !rsp_cycle_found, rsp_frequency_q8 == '0 && rsp_velocity_q8 == '0)
   // A zero frequency always comes with a zero velocity.
   `ASSERT_IMPLIES(a_vel_needs_freq, clock, reset, rsp_valid && rsp_frequency_q8 == '0, rsp_velocity_q8 == '0)

endmodule

bind hand_oscillation_rate_detector hord_checker u_hord_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_in_region    (rsp_in_region),
   .rsp_cycle_found  (rsp_cycle_found),
   .rsp_frequency_q8 (rsp_frequency_q8),
   .rsp_velocity_q8  (rsp_velocity_q8)
);

`default_nettype wire

FILE: tb/hord_frame_checker.sv
// Scoreboard for the hand oscillation rate detector: predicts each frame's result and compares.
// Depends on hord_pkg; watches the frame, result and register ports beside the block.
`timescale 1ns / 1ps

module hord_frame_checker #(
   parameter int COORD_W = 12,
   parameter int TIME_W  = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire                                  req_stall,
   input  wire  [COORD_W-1:0]                   req_left_y,
   input  wire  [COORD_W-1:0]                   req_right_y,
   input  wire  [COORD_W-1:0]                   req_head_y,
   input  wire  [TIME_W-1:0]                    req_time_ticks,
   input  wire                                  rsp_valid,
   input  wire                                  rsp_stall,
   input  wire                                  rsp_in_region,
   input  wire                                  rsp_cycle_found,
   input  wire  [hord_pkg::FREQ_BITS-1:0]       rsp_frequency_q8,
   input  wire  signed [hord_pkg::VEL_BITS-1:0] rsp_velocity_q8,
   input  wire  [hord_pkg::SAMPLE_BITS-1:0]     rsp_sample_time,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire                                  csr_pready,
   input  wire  [hord_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire  [hord_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output int                                   results_checked,
   output int                                   fail_count
);
   import hord_pkg::*;

   localparam longint VEL_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint VEL_LO = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic                        in_region;
      logic                        cycle_found;
      logic [FREQ_BITS-1:0]        freq;
      logic signed [VEL_BITS-1:0]  vel;
      logic [SAMPLE_BITS-1:0]      stamp;
   } frame_result_type;

   logic [HM_BITS-1:0]  margin;
   logic [THR_BITS-1:0] threshold;
   logic [TPS_BITS-1:0] tps;

   logic                rising;
   logic [COORD_W-1:0]  prev_ctr;
   logic [COORD_W-1:0]  low_turn;
   logic [COORD_W-1:0]  high_turn;
   logic                skip_armed;
   logic [TIME_W-1:0]   cycle_start;

   frame_result_type    expected_q[$];
   frame_result_type    want;
   int                  done_cnt;
   int                  fail_cnt;

   function automatic frame_result_type track_frame(input logic [COORD_W-1:0] ly,
                                                    input logic [COORD_W-1:0] ry,
                                                    input logic [COORD_W-1:0] hy,
                                                    input logic [TIME_W-1:0]  now);
      frame_result_type r;
      logic [COORD_W+1:0]  sum2;
      logic [COORD_W+3:0]  limit2;
      logic [COORD_W:0]    ctr;
      logic [TIME_W-1:0]   period;
      logic [63:0]         quo;
      longint              diff;
      longint              height;
      longint              swing;
      longint              vel;
      r = '0;
      r.stamp = SAMPLE_BITS'(now);
      sum2 = (COORD_W+2)'(ly) + (COORD_W+2)'(ry);
      limit2 = ((COORD_W+4)'(hy) + (COORD_W+4)'(margin)) << 1;
      if (!((COORD_W+4)'(sum2) < limit2)) begin
         skip_armed = 1'b1;
         return r;
      end
      ctr = sum2[COORD_W+1:1];
      if (sum2[0] && ctr[0]) ctr = ctr + (COORD_W+1)'(1);
      diff = longint'(ctr) - longint'(prev_ctr);
      if (rising) begin
         if (diff > 0) begin
            height = longint'(low_turn) - longint'(high_turn);
            if (height > longint'(threshold)) begin
               period = now - cycle_start;
               cycle_start = now;
               if (skip_armed) begin
                  skip_armed = 1'b0;
               end else begin
                  if (period == '0) begin
                     r.freq = '1;
                  end else begin
                     quo = {24'd0, tps, 8'd0} / 64'(period);
                     r.freq = (quo > 64'hFFFF_FFFF) ? '1 : quo[FREQ_BITS-1:0];
                  end
                  swing = 2 * longint'(low_turn) - longint'(high_turn) + longint'(prev_ctr);
                  vel = swing * longint'(r.freq);
                  if (vel > VEL_HI) vel = VEL_HI;
                  if (vel < VEL_LO) vel = VEL_LO;
                  r.vel = vel[VEL_BITS-1:0];
                  r.cycle_found = 1'b1;
               end
               rising = 1'b0;
            end
            high_turn = prev_ctr;
         end
      end else if (diff < 0) begin
         low_turn = prev_ctr;
         rising = 1'b1;
      end
      prev_ctr = ctr[COORD_W-1:0];
      r.in_region = 1'b1;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                       input logic signed [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         margin      = HEAD_MARGIN_RESET;
         threshold   = THRESHOLD_RESET;
         tps         = TPS_RESET;
         rising      = 1'b0;
         prev_ctr    = '0;
         low_turn    = '0;
         high_turn   = '0;
         skip_armed  = 1'b0;
         cycle_start = '0;
         expected_q.delete();
         done_cnt    = 0;
         fail_cnt    = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_BITS-1:2])
               REG_HEAD_MARGIN:      margin = csr_pwdata[HM_BITS-1:0];
               REG_DIST_THRESHOLD:   threshold = csr_pwdata[THR_BITS-1:0];
               REG_TICKS_PER_SECOND: tps = csr_pwdata[TPS_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_q.push_back(track_frame(req_left_y, req_right_y, req_head_y,
                                             req_time_ticks));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transaction arrived with no frame outstanding");
               fail_cnt++;
            end else begin
               want = expected_q.pop_front();
               check_field("in_region", 64'(want.in_region), 64'(rsp_in_region));
               check_field("cycle_found", 64'(want.cycle_found), 64'(rsp_cycle_found));
               check_field("frequency_q8", 64'(want.freq), 64'(rsp_frequency_q8));
               check_field("velocity_q8", 64'($signed(want.vel)), 64'(rsp_velocity_q8));
               check_field("sample_time", 64'(want.stamp), 64'(rsp_sample_time));
            end
            done_cnt++;
         end
      end
      results_checked <= done_cnt;
      fail_count      <= fail_cnt;
   end

endmodule

FILE: tb/tb_top.sv
// Top of the hand oscillation rate detector testbench: clock, reset, frame and register stimulus.
// Depends on hord_pkg, hand_oscillation_rate_detector and hord_frame_checker.
`timescale 1ns / 1ps

module tb_top;
   import hord_pkg::*;

   localparam int COORD_W = 12;
   localparam int TIME_W  = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [COORD_W-1:0]          req_left_y = '0;
   logic [COORD_W-1:0]          req_right_y = '0;
   logic [COORD_W-1:0]          req_head_y = '0;
   logic [TIME_W-1:0]           req_time_ticks = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_in_region;
   logic                        rsp_cycle_found;
   logic [FREQ_BITS-1:0]        rsp_frequency_q8;
   logic signed [VEL_BITS-1:0]  rsp_velocity_q8;
   logic [SAMPLE_BITS-1:0]      rsp_sample_time;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]    csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]    csr_prdata;
   logic                        csr_pready;

   logic                        idle_on = 1'b1;
   int                          hold_cnt = 0;
   int                          cycle_count = 0;
   int                          frames_sent = 0;
   int                          results_checked;
   int                          fail_count;
   logic [TIME_W-1:0]           stamp;

   hand_oscillation_rate_detector #(
      .COORD_BITS(COORD_W),
      .TIME_BITS (TIME_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_y      (req_left_y),
      .req_right_y     (req_right_y),
      .req_head_y      (req_head_y),
      .req_time_ticks  (req_time_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_in_region   (rsp_in_region),
      .rsp_cycle_found (rsp_cycle_found),
      .rsp_frequency_q8(rsp_frequency_q8),
      .rsp_velocity_q8 (rsp_velocity_q8),
      .rsp_sample_time (rsp_sample_time),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   hord_frame_checker #(
      .COORD_W(COORD_W),
      .TIME_W (TIME_W)
   ) frame_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_y      (req_left_y),
      .req_right_y     (req_right_y),
      .req_head_y      (req_head_y),
      .req_time_ticks  (req_time_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_in_region   (rsp_in_region),
      .rsp_cycle_found (rsp_cycle_found),
      .rsp_frequency_q8(rsp_frequency_q8),
      .rsp_velocity_q8 (rsp_velocity_q8),
      .rsp_sample_time (rsp_sample_time),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .results_checked (results_checked),
      .fail_count      (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      else if (r < 96) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [TIME_W-1:0] pick_dt();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1000, 200000);
      else if (r == 7) return '0;
      else if (r == 8) return $urandom_range(1, 10);
      else return $urandom();
   endfunction

   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (!rsp_stall && idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= pick_gap() - 1;
      end else begin
         rsp_stall <= 1'b0;
         hold_cnt  <= $urandom_range(0, 6);
      end
   end

   task automatic send_frame(input logic [COORD_W-1:0] ly, input logic [COORD_W-1:0] ry,
                             input logic [COORD_W-1:0] hy, input logic [TIME_W-1:0] t);
      int gap;
      gap = (idle_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_left_y     <= ly;
      req_right_y    <= ry;
      req_head_y     <= hy;
      req_time_ticks <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
   endtask

   task automatic send_noise();
      stamp = stamp + pick_dt();
      send_frame(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)),
                 COORD_W'($urandom_range(0, 4095)), stamp);
   endtask

   task automatic send_center(input int c, input logic [COORD_W-1:0] hy);
      int sum;
      int ly;
      sum = 2 * c + $urandom_range(0, 1);
      if (sum > 8190) sum = 8190;
      ly = $urandom_range(sum > 4095 ? sum - 4095 : 0, sum < 4095 ? sum : 4095);
      stamp = stamp + pick_dt();
      send_frame(COORD_W'(ly), COORD_W'(sum - ly), hy, stamp);
   endtask

   // Hands swing between two heights that stay inside the region for the chosen head.
   task automatic run_swings(input logic [THR_BITS-1:0] thr);
      int amp;
      int bottom;
      int top_c;
      int halves;
      int steps;
      int from_c;
      int to_c;
      logic [COORD_W-1:0] hy;
      amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, thr + 2)
                                         : thr + $urandom_range(1, 400);
      if (amp > 4094) amp = 4094;
      bottom = $urandom_range(amp, 4094);
      top_c  = bottom - amp;
      hy     = COORD_W'($urandom_range(bottom + 1, 4095));
      halves = $urandom_range(2, 8);
      from_c = top_c;
      for (int h = 0; h < halves; h++) begin
         to_c  = (h % 2 == 0) ? bottom : top_c;
         steps = $urandom_range(1, 4);
         for (int k = 1; k <= steps; k++) begin
            if ($urandom_range(0, 24) == 0) send_noise();
            else send_center(from_c + (to_c - from_c) * k / steps, hy);
         end
         from_c = to_c;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_checked != frames_sent) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic apply_config(input logic [HM_BITS-1:0] hm, input logic [THR_BITS-1:0] thr,
                               input logic [TPS_BITS-1:0] tps);
      drain();
      csr_write(REG_HEAD_MARGIN, CSR_DATA_BITS'(hm));
      csr_write(REG_DIST_THRESHOLD, CSR_DATA_BITS'(thr));
      csr_write(REG_TICKS_PER_SECOND, CSR_DATA_BITS'(tps));
      csr_write(REG_UNUSED, $urandom());
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [HM_BITS-1:0]  hm;
      logic [THR_BITS-1:0] thr;
      logic [TPS_BITS-1:0] tps;
      int                  goal;
      stamp = $urandom();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: extremes, region boundary, rounding ties, skipped and
      // zero-period cycles.
      send_frame(0, 0, 0, 0);
      send_frame(4095, 4095, 4095, 32'hFFFF_FFFF);
      send_frame(4095, 4095, 0, 5);
      send_frame(200, 200, 100, 6);
      send_frame(200, 199, 100, 10);
      send_frame(101, 100, 100, 20);
      send_frame(110, 110, 100, 100);
      send_frame(300, 300, 300, 200);
      send_frame(150, 150, 300, 300);
      send_frame(160, 160, 300, 1100);
      send_frame(400, 400, 500, 1100);
      send_frame(100, 100, 500, 1100);
      send_frame(200, 200, 500, 1100);

      // Largest margin, zero threshold and zero tick rate.
      apply_config(12'd4095, 12'd0, 32'd0);
      send_frame(300, 300, 0, 2000);
      send_frame(250, 250, 0, 2500);
      send_frame(260, 260, 0, 3000);
      send_frame(500, 500, 0, 3000);
      send_frame(200, 200, 0, 3000);
      send_frame(300, 300, 0, 3000);

      // No margin, largest threshold and tick rate, then zero threshold; timestamps wrapping.
      apply_config(12'd0, 12'd4095, 32'hFFFF_FFFF);
      send_frame(4000, 4000, 4095, 32'hFFFF_FFF0);
      send_frame(0, 0, 4095, 32'hFFFF_FFF8);
      send_frame(10, 10, 4095, 32'd4);
      apply_config(12'd0, 12'd0, 32'hFFFF_FFFF);
      send_frame(3000, 3001, 4095, 32'd5);
      send_frame(2000, 2000, 4095, 32'd6);
      send_frame(2100, 2100, 4095, 32'd6);

      for (int p = 0; p < 10; p++) begin
         case ($urandom_range(0, 3))
            0:       hm = '0;
            1:       hm = '1;
            default: hm = HM_BITS'($urandom_range(0, 4095));
         endcase
         case ($urandom_range(0, 7))
            0:       thr = '0;
            1:       thr = '1;
            default: thr = THR_BITS'($urandom_range(0, 150));
         endcase
         case ($urandom_range(0, 3))
            0:       tps = 32'd1;
            1:       tps = '1;
            2:       tps = 32'd1000000;
            default: tps = $urandom();
         endcase
         apply_config(hm, thr, tps);
         idle_on <= ($urandom_range(0, 3) != 0);
         goal = frames_sent + 100;
         while (frames_sent < goal) begin
            if ($urandom_range(0, 6) == 0) send_noise();
            else run_swings(thr);
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
